// ===== sv/prt_pkg.sv =====
// Shared codes, defaults and controller/datapath interface types for the request tracker.
package prt_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_RESP  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_RESP  = 2'd1;
    localparam logic [1:0] KIND_EXP   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MASTER   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    // Field widths fixed by the interface.
    localparam int CONN_W  = 12;
    localparam int IDENT_W = 8;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 31;
    localparam int RES_W   = 16;

    // Defaults.
    localparam int              ENTRIES_DEFAULT = 8;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 31'd30000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input word, reset the scan
        logic start_do;  // answer a start request
        logic scan_step; // examine one table entry
        logic resp_do;   // answer a response
        logic exp_step;  // one step of the expiry emission walk
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;       // captured command code
        logic       scan_done; // current scan step is the last entry
        logic       exp_none;  // no expired entries left to emit
        logic       out_free;  // output register can take a word this cycle
    } t_dp_stat;

endpackage

// ===== sv/pending_request_tracker.sv =====
// Top level of the pending request tracker: controller, datapath and configuration port.
// The tracker holds up to ENTRIES outstanding parameter-update requests. A start is
// answered once dispatched. Responses and ticks first walk over the table, one entry per
// cycle: a response is answered after its scan, and a tick's scan is followed by an
// emission walk over the age ranks, one expired entry emitted per step, newest first.
// The next word is accepted once the previous one is finished; its last answer may
// still wait in the output register. Stalls on the output side hold up the answers.
// The timeout register can be written at any time the tracker is idle and always
// accepts the write.
module pending_request_tracker #(
    parameter int ENTRIES = prt_pkg::ENTRIES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [prt_pkg::CONN_W-1:0]   i_conn_handle,
    input  logic                         i_is_master,
    input  logic [prt_pkg::IDENT_W-1:0]  i_ident,
    input  logic [prt_pkg::RES_W-1:0]    i_result_code,
    input  logic [prt_pkg::TIME_W-1:0]   i_now,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_kind,
    output logic [2:0]                   o_status,
    output logic [prt_pkg::CONN_W-1:0]   o_out_conn,
    output logic [prt_pkg::IDENT_W-1:0]  o_out_ident,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [prt_pkg::TMO_W-1:0]    i_cfg_data
);
    import prt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The timeout register takes every write at once.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    prt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table and result path.
    prt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_conn_handle (i_conn_handle),
        .i_is_master   (i_is_master),
        .i_ident       (i_ident),
        .i_result_code (i_result_code),
        .i_now         (i_now),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_out_conn    (o_out_conn),
        .o_out_ident   (o_out_ident),
        .o_last        (o_last)
    );

endmodule

// ===== sv/prt_ctrl.sv =====
// Controller state machine that sequences start, response and tick handling.
module prt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  prt_pkg::t_dp_stat i_stat,
    output prt_pkg::t_dp_cmd  o_cmd
);
    import prt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_START,
        S_SCAN,
        S_RESP,
        S_EXP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_START: n_state = S_START;
                    CMD_RESP:  n_state = S_SCAN;
                    CMD_TICK:  n_state = S_SCAN;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_START: begin
                if (i_stat.out_free) begin
                    o_cmd.start_do = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = (i_stat.cmd == CMD_RESP) ? S_RESP : S_EXP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_do = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_EXP: begin
                if (i_stat.exp_none) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.exp_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// ===== sv/prt_dpath.sv =====
// Datapath: request table, scan unit, expiry walk and output register.
module prt_dpath #(
    parameter int ENTRIES = prt_pkg::ENTRIES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_command,
    input  logic [prt_pkg::CONN_W-1:0]   i_conn_handle,
    input  logic                         i_is_master,
    input  logic [prt_pkg::IDENT_W-1:0]  i_ident,
    input  logic [prt_pkg::RES_W-1:0]    i_result_code,
    input  logic [prt_pkg::TIME_W-1:0]   i_now,
    input  logic                         i_cfg_valid,
    input  logic [prt_pkg::TMO_W-1:0]    i_cfg_data,
    input  logic                         i_out_ready,
    input  prt_pkg::t_dp_cmd             i_cmd,
    output prt_pkg::t_dp_stat            o_stat,
    output logic                         o_out_valid,
    output logic [1:0]                   o_kind,
    output logic [2:0]                   o_status,
    output logic [prt_pkg::CONN_W-1:0]   o_out_conn,
    output logic [prt_pkg::IDENT_W-1:0]  o_out_ident,
    output logic                         o_last
);
    import prt_pkg::*;

    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

    // Table.
    logic [ENTRIES-1:0] r_valid;
    logic [CONN_W-1:0]  r_conn   [ENTRIES];
    logic [IDENT_W-1:0] r_tident [ENTRIES];
    logic [TIME_W-1:0]  r_dline  [ENTRIES];
    logic [IdxW-1:0]    r_rank   [ENTRIES];
    logic [IDENT_W-1:0] r_last_ident;
    logic [TMO_W-1:0]   r_timeout;

    // Captured input word.
    logic [1:0]         r_cmd;
    logic [CONN_W-1:0]  r_in_conn;
    logic               r_in_master;
    logic [IDENT_W-1:0] r_in_ident;
    logic [RES_W-1:0]   r_in_result;
    logic [TIME_W-1:0]  r_in_now;

    // Scan and expiry state.
    logic [IdxW-1:0]    r_idx;
    logic               r_found;
    logic [IdxW-1:0]    r_best;
    logic [IdxW-1:0]    r_best_rank;
    logic [ENTRIES-1:0] r_expired;
    logic [IdxW-1:0]    r_cursor;

    // Output register.
    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic [2:0]         r_status;
    logic [CONN_W-1:0]  r_oconn;
    logic [IDENT_W-1:0] r_oident;
    logic               r_last;

    // Combinational helpers.
    logic               out_free;
    logic               full;
    logic [IdxW-1:0]    free_slot;
    logic [IDENT_W-1:0] n_ident;
    logic               alloc_en;
    logic               scan_hit;
    logic [TIME_W-1:0]  scan_diff;
    logic [ENTRIES-1:0] exp_hit;
    logic               exp_any;
    logic [CONN_W-1:0]  exp_conn;
    logic [IDENT_W-1:0] exp_ident;
    logic               drop_en;
    logic [ENTRIES-1:0] drop_mask;
    logic [IdxW-1:0]    drop_rank;
    logic               load_out;
    logic [1:0]         n_kind;
    logic [2:0]         n_status;
    logic [CONN_W-1:0]  n_oconn;
    logic [IDENT_W-1:0] n_oident;
    logic               n_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = &r_valid;

    // Lowest free slot.
    always_comb begin
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IdxW'(i);
            end
        end
    end

    // Next identifier, skipping zero.
    always_comb begin
        n_ident = r_last_ident + 1'b1;
        if (n_ident == '0) begin
            n_ident = IDENT_W'(1);
        end
    end

    assign alloc_en = i_cmd.start_do && !r_in_master && !full;

    // One entry of the scan: response match and expiry test.
    assign scan_hit  = r_valid[r_idx] && (r_conn[r_idx] == r_in_conn)
                       && (r_tident[r_idx] == r_in_ident);
    assign scan_diff = r_in_now - r_dline[r_idx];

    // Expired entry at the current rank cursor.
    always_comb begin
        exp_conn  = '0;
        exp_ident = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            exp_hit[i] = r_expired[i] && (r_rank[i] == r_cursor);
            if (exp_hit[i]) begin
                exp_conn  = exp_conn | r_conn[i];
                exp_ident = exp_ident | r_tident[i];
            end
        end
        exp_any = |exp_hit;
    end

    // Entry removal, shared by response match and expiry.
    always_comb begin
        drop_en   = 1'b0;
        drop_mask = '0;
        drop_rank = r_best_rank;
        if (i_cmd.resp_do && r_found) begin
            drop_en = 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
                drop_mask[i] = (r_best == IdxW'(i));
            end
        end else if (i_cmd.exp_step && exp_any) begin
            drop_en   = 1'b1;
            drop_mask = exp_hit;
            drop_rank = r_cursor;
        end
    end

    // Result word selection.
    always_comb begin
        load_out = 1'b0;
        n_kind   = KIND_START;
        n_status = ST_OK;
        n_oconn  = r_in_conn;
        n_oident = '0;
        n_last   = 1'b1;
        if (i_cmd.start_do) begin
            load_out = 1'b1;
            if (r_in_master) begin
                n_status = ST_MASTER;
            end else if (full) begin
                n_status = ST_FULL;
            end else begin
                n_oident = n_ident;
            end
        end else if (i_cmd.resp_do) begin
            load_out = 1'b1;
            n_kind   = KIND_RESP;
            if (!r_found) begin
                n_status = ST_NOTFOUND;
            end else begin
                n_oident = r_in_ident;
                if (r_in_result == '0) begin
                    n_status = ST_OK;
                end else if (r_in_result == RES_W'(1)) begin
                    n_status = ST_REJECTED;
                end else begin
                    n_status = ST_BAD;
                end
            end
        end else if (i_cmd.exp_step && exp_any) begin
            load_out = 1'b1;
            n_kind   = KIND_EXP;
            n_oconn  = exp_conn;
            n_oident = exp_ident;
            n_last   = ((r_expired & ~exp_hit) == '0);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_last_ident <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_expired    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (alloc_en) begin
                r_last_ident        <= n_ident;
                r_valid[free_slot]  <= 1'b1;
            end else if (drop_en) begin
                r_valid <= r_valid & ~drop_mask;
            end
            if (i_cmd.capture) begin
                r_expired <= '0;
            end else if (i_cmd.scan_step) begin
                r_expired[r_idx] <= r_valid[r_idx] && !scan_diff[TIME_W-1];
            end else if (drop_en) begin
                r_expired <= r_expired & ~drop_mask;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Table payload and age order.
    always_ff @(posedge i_clk) begin
        if (alloc_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i]) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            r_rank[free_slot]   <= '0;
            r_conn[free_slot]   <= r_in_conn;
            r_tident[free_slot] <= n_ident;
            r_dline[free_slot]  <= r_in_now + {1'b0, r_timeout};
        end else if (drop_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && !drop_mask[i] && (r_rank[i] > drop_rank)) begin
                    r_rank[i] <= r_rank[i] - 1'b1;
                end
            end
        end
    end

    // Input capture, scan walk and rank cursor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd       <= i_command;
            r_in_conn   <= i_conn_handle;
            r_in_master <= i_is_master;
            r_in_ident  <= i_ident;
            r_in_result <= i_result_code;
            r_in_now    <= i_now;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_cursor    <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_idx <= (r_idx == LastIdx) ? '0 : r_idx + 1'b1;
                if (scan_hit && (!r_found || (r_rank[r_idx] < r_best_rank))) begin
                    r_found     <= 1'b1;
                    r_best      <= r_idx;
                    r_best_rank <= r_rank[r_idx];
                end
            end
            if (i_cmd.exp_step && !exp_any) begin
                r_cursor <= r_cursor + 1'b1;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_kind   <= n_kind;
            r_status <= n_status;
            r_oconn  <= n_oconn;
            r_oident <= n_oident;
            r_last   <= n_last;
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.scan_done = (r_idx == LastIdx);
    assign o_stat.exp_none  = (r_expired == '0);
    assign o_stat.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_status    = r_status;
    assign o_out_conn  = r_oconn;
    assign o_out_ident = r_oident;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    // A new word is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(load_out && r_out_valid && !i_out_ready))
        else $error("output word overwritten while stalled");

    // Every expired mark belongs to a live entry.
    a_expired_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_expired & ~r_valid) == '0))
        else $error("expired mark on a free entry");

    // Any live entry means an identifier has been handed out.
    a_ident_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_valid) |-> (r_last_ident != '0))
        else $error("live entry with zero last identifier");

    // A successful start leaves the chosen slot live with the new identifier.
    a_alloc_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc_en |=> (r_valid[$past(free_slot)] && (r_last_ident == $past(n_ident))))
        else $error("allocation did not take effect");
`endif

endmodule

// ===== tb/tb_pending_request_tracker.sv =====
// Self-checking testbench for the pending request tracker, with a model of the request table.
`timescale 1ns / 100ps

module tb_pending_request_tracker;
    import prt_pkg::*;

    localparam int SLOTS = ENTRIES_DEFAULT;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CONN_W-1:0] WRAP_CONN = 12'hC3C;

    // One answer word as it leaves the tracker.
    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         status;
        logic [CONN_W-1:0]  conn;
        logic [IDENT_W-1:0] ident;
        logic               last;
    } t_answer;

    // Mirror of the request table that predicts every answer word.
    class request_table_check;
        t_answer            answers_due[$];
        logic               slot_valid[SLOTS];
        logic [CONN_W-1:0]  slot_conn[SLOTS];
        logic [IDENT_W-1:0] slot_ident[SLOTS];
        logic [TIME_W-1:0]  slot_deadline[SLOTS];
        logic [2:0]         slot_age[SLOTS];
        logic [IDENT_W-1:0] last_ident;
        logic [TMO_W-1:0]   timeout;
        int                 mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
            end
            last_ident = '0;
            timeout = TIMEOUT_RESET;
            mismatches = 0;
        endfunction

        function void set_timeout(logic [TMO_W-1:0] value);
            timeout = value;
        endfunction

        function int due();
            return answers_due.size();
        endfunction

        // A random occupied slot, or -1 when the table is empty.
        function int any_slot();
            int live[$];
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i]) live.push_back(i);
            end
            if (live.size() == 0) return -1;
            return live[$urandom_range(0, live.size() - 1)];
        endfunction

        function void expect_answer(logic [1:0] kind, logic [2:0] status,
                                    logic [CONN_W-1:0] conn, logic [IDENT_W-1:0] ident,
                                    logic last);
            t_answer a;
            a.kind = kind;
            a.status = status;
            a.conn = conn;
            a.ident = ident;
            a.last = last;
            answers_due.push_back(a);
        endfunction

        // Free a slot and close the gap it leaves in the age order.
        function void retire(int s);
            logic [2:0] age;
            age = slot_age[s];
            slot_valid[s] = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && slot_age[i] > age) slot_age[i] = slot_age[i] - 3'd1;
            end
        endfunction

        // Apply one accepted input word and queue the answers it causes.
        function void note_word(logic [1:0] cmd, logic [CONN_W-1:0] conn, logic master,
                                logic [IDENT_W-1:0] ident, logic [RES_W-1:0] rc,
                                logic [TIME_W-1:0] now);
            int free_slot;
            int best;
            int order[$];
            logic hit[SLOTS];
            logic [TIME_W-1:0] gap;
            logic [2:0] status;
            free_slot = -1;
            best = -1;
            case (cmd)
                CMD_START: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!slot_valid[i] && free_slot < 0) free_slot = i;
                    end
                    if (master) begin
                        expect_answer(KIND_START, ST_MASTER, conn, '0, 1'b1);
                    end else if (free_slot < 0) begin
                        expect_answer(KIND_START, ST_FULL, conn, '0, 1'b1);
                    end else begin
                        // Identifiers run 1..255 and skip zero on wrap.
                        last_ident = last_ident + 8'd1;
                        if (last_ident == '0) last_ident = 8'd1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (slot_valid[i]) slot_age[i] = slot_age[i] + 3'd1;
                        end
                        slot_valid[free_slot] = 1'b1;
                        slot_age[free_slot] = '0;
                        slot_conn[free_slot] = conn;
                        slot_ident[free_slot] = last_ident;
                        slot_deadline[free_slot] = now + {1'b0, timeout};
                        expect_answer(KIND_START, ST_OK, conn, last_ident, 1'b1);
                    end
                end
                CMD_RESP: begin
                    // The newest matching request wins.
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_valid[i] && slot_conn[i] == conn && slot_ident[i] == ident) begin
                            if (best < 0 || slot_age[i] < slot_age[best]) best = i;
                        end
                    end
                    if (best < 0) begin
                        expect_answer(KIND_RESP, ST_NOTFOUND, conn, '0, 1'b1);
                    end else begin
                        retire(best);
                        status = (rc == 16'd0) ? ST_OK : (rc == 16'd1) ? ST_REJECTED : ST_BAD;
                        expect_answer(KIND_RESP, status, conn, ident, 1'b1);
                    end
                end
                CMD_TICK: begin
                    // Expired when the signed distance past the deadline is not negative.
                    for (int i = 0; i < SLOTS; i++) begin
                        gap = now - slot_deadline[i];
                        hit[i] = slot_valid[i] && !gap[TIME_W-1];
                    end
                    for (int r = 0; r < SLOTS; r++) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (hit[i] && int'(slot_age[i]) == r) order.push_back(i);
                        end
                    end
                    foreach (order[k]) begin
                        expect_answer(KIND_EXP, ST_OK, slot_conn[order[k]], slot_ident[order[k]],
                                      k == order.size() - 1);
                    end
                    // Oldest first, so the remaining ages stay consistent.
                    for (int k = order.size() - 1; k >= 0; k--) begin
                        retire(order[k]);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one delivered word with the oldest prediction.
        function void check_answer(t_answer got);
            t_answer want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected answer: kind=%0d status=%0d conn=%03h ident=%0d last=%0d",
                             got.kind, got.status, got.conn, got.ident, got.last);
                end
                return;
            end
            want = answers_due.pop_front();
            if (got.kind !== want.kind || got.status !== want.status || got.conn !== want.conn ||
                got.ident !== want.ident || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("answer mismatch: expected kind=%0d status=%0d conn=%03h ident=%0d last=%0d",
                             want.kind, want.status, want.conn, want.ident, want.last);
                    $display("                 actual   kind=%0d status=%0d conn=%03h ident=%0d last=%0d",
                             got.kind, got.status, got.conn, got.ident, got.last);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          in_command;
    logic [CONN_W-1:0]   in_conn;
    logic                in_master;
    logic [IDENT_W-1:0]  in_ident;
    logic [RES_W-1:0]    in_result;
    logic [TIME_W-1:0]   in_now;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          out_kind;
    logic [2:0]          out_status;
    logic [CONN_W-1:0]   out_conn;
    logic [IDENT_W-1:0]  out_ident;
    logic                out_last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TMO_W-1:0]    cfg_data;

    logic                calm;
    logic [TIME_W-1:0]   now_t;
    logic [CONN_W-1:0]   conn_pool[4] = '{12'h000, 12'hFFF, 12'h123, 12'hEDC};

    request_table_check tracker_chk = new();

    pending_request_tracker i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (in_command),
        .i_conn_handle (in_conn),
        .i_is_master   (in_master),
        .i_ident       (in_ident),
        .i_result_code (in_result),
        .i_now         (in_now),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_kind        (out_kind),
        .o_status      (out_status),
        .o_out_conn    (out_conn),
        .o_out_ident   (out_ident),
        .o_last        (out_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    // 4 ns clock.
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stall bursts, always ready once the run goes calm.
    initial begin
        int stall;
        out_ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge clk);
            if (calm) begin
                out_ready <= 1'b1;
            end else if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else if ($urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(0, 11);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every delivered answer word is checked at the edge that takes it.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            tracker_chk.check_answer({out_kind, out_status, out_conn, out_ident, out_last});
        end
    end

    // Present one input word, hold it until taken, then maybe leave a gap.
    task automatic send_word(input logic [1:0] cmd, input logic [CONN_W-1:0] conn,
                             input logic master, input logic [IDENT_W-1:0] ident,
                             input logic [RES_W-1:0] rc, input logic [TIME_W-1:0] now);
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_conn    <= conn;
        in_master  <= master;
        in_ident   <= ident;
        in_result  <= rc;
        in_now     <= now;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker_chk.note_word(cmd, conn, master, ident, rc, now);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // Stop sending and let every predicted answer arrive, plus the longest scan.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker_chk.due() != 0) @(negedge clk);
        repeat (4 * SLOTS + 8) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TMO_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        tracker_chk.set_timeout(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Answer every open request with its own connection and identifier.
    task automatic answer_all();
        int s;
        s = tracker_chk.any_slot();
        while (s >= 0) begin
            send_word(CMD_RESP, tracker_chk.slot_conn[s], 1'b0, tracker_chk.slot_ident[s],
                      RES_W'($urandom), now_t);
            s = tracker_chk.any_slot();
        end
    endtask

    // One random word: mostly starts and matching responses, some ticks and noise.
    task automatic random_word(input int now_step, input bit wild, output bit counted);
        int pick;
        int s;
        logic [1:0] cmd;
        logic [CONN_W-1:0] conn;
        logic master;
        logic [IDENT_W-1:0] ident;
        logic [RES_W-1:0] rc;
        pick = $urandom_range(0, 99);
        conn = ($urandom_range(0, 2) == 0) ? CONN_W'($urandom) : conn_pool[$urandom_range(0, 3)];
        master = 1'b0;
        ident = IDENT_W'($urandom);
        rc = RES_W'($urandom);
        if (wild || $urandom_range(0, 19) == 0) now_t = $urandom;
        else now_t = now_t + $urandom_range(0, now_step);
        if (pick < 45) begin
            cmd = CMD_START;
            master = ($urandom_range(0, 9) == 0);
        end else if (pick < 75) begin
            cmd = CMD_RESP;
            s = tracker_chk.any_slot();
            if (s >= 0 && $urandom_range(0, 3) != 0) begin
                ident = tracker_chk.slot_ident[s];
                if ($urandom_range(0, 5) != 0) conn = tracker_chk.slot_conn[s];
            end else if ($urandom_range(0, 3) == 0) begin
                ident = '0;
            end
            case ($urandom_range(0, 2))
                0: rc = '0;
                1: rc = 16'd1;
                default: begin
                end
            endcase
        end else if (pick < 95) begin
            cmd = CMD_TICK;
        end else begin
            cmd = CMD_UNUSED;
            master = 1'($urandom);
        end
        counted = (cmd != CMD_UNUSED);
        send_word(cmd, conn, master, ident, rc, now_t);
    endtask

    task automatic random_phase(input logic [TMO_W-1:0] tmo, input int count,
                                input int now_step, input bit wild);
        int done_words;
        bit counted;
        write_timeout(tmo);
        done_words = 0;
        while (done_words < count) begin
            random_word(now_step, wild, counted);
            if (counted) done_words++;
        end
    endtask

    localparam logic [TIME_W-1:0] T0 = 32'hFFFF_FFF0;

    initial begin
        int alloc;
        logic [CONN_W-1:0] conn;
        logic [CONN_W-1:0] start_conns[SLOTS];
        start_conns = '{12'h000, 12'hFFF, 12'h5A5, 12'hA5A,
                        12'h001, 12'h002, 12'h003, 12'h800};
        rst_n      = 1'b0;
        calm       = 1'b0;
        in_valid   = 1'b0;
        in_command = CMD_TICK;
        in_conn    = '0;
        in_master  = 1'b0;
        in_ident   = '0;
        in_result  = '0;
        in_now     = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        now_t      = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: refusals, empty lookups, a full table, each response outcome,
        // expiry across the time wrap, all under the reset timeout.
        send_word(CMD_START, 12'hFFF, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_RESP, 12'h000, 1'b0, 8'h00, 16'h0000, 32'h0);
        send_word(CMD_UNUSED, 12'hFFF, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_TICK, 12'h000, 1'b0, 8'h00, 16'h0000, 32'h0);
        for (int i = 0; i < SLOTS; i++) begin
            send_word(CMD_START, start_conns[i], 1'b0, 8'h00, 16'h0000, T0 + 4 * i);
        end
        send_word(CMD_START, 12'h7E7, 1'b0, 8'h00, 16'h0000, T0 + 40);
        send_word(CMD_START, 12'h7E7, 1'b1, 8'h00, 16'h0000, T0 + 40);
        send_word(CMD_RESP, 12'h5A5, 1'b0, 8'd3, 16'd0, T0 + 44);
        send_word(CMD_RESP, 12'h001, 1'b0, 8'd5, 16'd1, T0 + 44);
        send_word(CMD_RESP, 12'hA5A, 1'b0, 8'd4, 16'hFFFF, T0 + 44);
        send_word(CMD_RESP, 12'hA5A, 1'b0, 8'd4, 16'd0, T0 + 44);
        send_word(CMD_RESP, 12'h000, 1'b0, 8'd255, 16'd0, T0 + 44);
        send_word(CMD_TICK, 12'h000, 1'b0, 8'h00, 16'h0000, T0 + 32'd30000);
        send_word(CMD_TICK, 12'h000, 1'b0, 8'h00, 16'h0000, T0 + 32'd30040);
        now_t = T0 + 32'd30050;
        send_word(CMD_START, 12'h3C3, 1'b0, 8'h00, 16'h0000, now_t);
        answer_all();

        // Identifier wrap: one long-lived request, then short ones that expire in
        // groups until its identifier is handed out again on the same connection.
        write_timeout(31'h7FFF_FFFF);
        now_t = $urandom;
        send_word(CMD_START, WRAP_CONN, 1'b0, '0, '0, now_t);
        write_timeout(31'd1);
        alloc = 0;
        while (alloc < 255) begin
            for (int k = 0; k < SLOTS - 1; k++) begin
                conn = (alloc >= 248 || $urandom_range(0, 1) == 1) ?
                       WRAP_CONN : CONN_W'($urandom);
                send_word(CMD_START, conn, 1'b0, IDENT_W'($urandom), RES_W'($urandom), now_t);
                alloc++;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_word(CMD_START, WRAP_CONN, 1'b0, '0, '0, now_t);
            end
            if (alloc < 255) begin
                now_t = now_t + 1;
                send_word(CMD_TICK, CONN_W'($urandom), 1'b0, IDENT_W'($urandom),
                          RES_W'($urandom), now_t);
            end
        end
        answer_all();

        // Random traffic under several timeouts; the last phase runs without idling.
        random_phase(31'd1, 35, 2, 1'b0);
        random_phase(TMO_W'($urandom_range(2, 40)), 35, 8, 1'b0);
        random_phase(31'h7FFF_FFFF, 35, 3, 1'b0);
        settle();
        calm = 1'b1;
        random_phase(TMO_W'($urandom_range(1, 32'h7FFF_FFFF)), 40, 0, 1'b1);

        settle();
        if (tracker_chk.mismatches == 0 && tracker_chk.due() == 0) begin
            $display("pending_request_tracker verification clean");
        end else begin
            $display("pending_request_tracker verification failed");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("pending_request_tracker verification failed");
        $finish;
    end

endmodule
